>>> rtl/ps2mt_pkg.sv
// ----------------------------------------------------------------------------
// PS/2 mouse packet tracker package
// Shared widths, register indexes, reset values, the byte phase type and the
// delta decode function.
// ----------------------------------------------------------------------------
package ps2mt_pkg;

   localparam int COORD_BITS_DEFAULT = 12;
   localparam int CSR_DATA_BITS      = 13;
   localparam int CSR_INDEX_BITS     = 1;
   localparam int DELTA_BITS         = 10;

   localparam logic [CSR_INDEX_BITS-1:0] REG_SCREEN_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SCREEN_HEIGHT = 1'd1;

   localparam logic [CSR_DATA_BITS-1:0] SCREEN_WIDTH_RESET  = 13'd1024;
   localparam logic [CSR_DATA_BITS-1:0] SCREEN_HEIGHT_RESET = 13'd768;

   typedef enum logic [1:0] {
      PHASE_HEADER = 2'd0,
      PHASE_X      = 2'd1,
      PHASE_Y      = 2'd2
   } phase_type;

   // Nine-bit signed delta from the low byte and sign bit, pushed a further
   // 255 in the direction of the sign when the overflow bit is set.
   function automatic logic signed [DELTA_BITS-1:0] decode_delta(
      input logic [7:0] low_byte,
      input logic       neg,
      input logic       ovf
   );
      logic signed [DELTA_BITS-1:0] base;
      logic signed [DELTA_BITS-1:0] extra;
      base  = $signed({neg, neg, low_byte});
      extra = ovf ? (neg ? -10'sd255 : 10'sd255) : 10'sd0;
      return base + extra;
   endfunction

endpackage

>>> rtl/ps2_mouse_packet_tracker.sv
// ----------------------------------------------------------------------------
// PS/2 mouse packet tracker
// Assembles three-byte PS/2 mouse packets, moves and clamps the cursor and
// reports the button levels and press flags once per packet.
//
//   channel  direction  beat contents
//   req_     in         rx_byte
//   rsp_     out        cursor_x, cursor_y, button levels, press flags
//   csr_     in         register index, write data (always ready)
//
// A byte may be accepted in every cycle, save when a third byte stalls as below.
// The third byte of a packet updates the cursor and loads the result
// register, whose beat appears on the next cycle.
// The third byte stalls only while the result register holds a beat that
// has not been taken; header and X bytes are accepted regardless.
// Reset is synchronous and returns the screen size to 1024 by 768, the cursor
// to the top left corner and the packet framing to the header byte.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_tracker
#(
   parameter int COORD_BITS = ps2mt_pkg::COORD_BITS_DEFAULT
)
(
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [7:0]                           req_rx_byte,

   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [COORD_BITS-1:0]                rsp_cursor_x,
   output logic [COORD_BITS-1:0]                rsp_cursor_y,
   output logic                                 rsp_left_down,
   output logic                                 rsp_right_down,
   output logic                                 rsp_middle_down,
   output logic                                 rsp_left_pressed,
   output logic                                 rsp_right_pressed,
   output logic                                 rsp_middle_pressed,

   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [ps2mt_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [ps2mt_pkg::CSR_DATA_BITS-1:0]  csr_data
);

   import ps2mt_pkg::*;

   localparam int SUM_BITS  = COORD_BITS + 3;
   localparam int WIDE_BITS = (COORD_BITS + 1 > CSR_DATA_BITS) ? COORD_BITS + 1
                                                              : CSR_DATA_BITS;

   phase_type                    phase_ff, phase_in;
   logic [7:0]                   header_ff, header_in;
   logic [7:0]                   x_byte_ff, x_byte_in;
   logic [COORD_BITS-1:0]        pos_x_ff, pos_x_in;
   logic [COORD_BITS-1:0]        pos_y_ff, pos_y_in;
   logic [2:0]                   prev_buttons_ff, prev_buttons_in;
   logic [CSR_DATA_BITS-1:0]     width_ff, width_in;
   logic [CSR_DATA_BITS-1:0]     height_ff, height_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [2:0]                   down_ff, down_in;
   logic [2:0]                   pressed_ff, pressed_in;

   logic                         req_fire;
   logic                         csr_fire;
   logic                         packet_done;
   logic signed [DELTA_BITS-1:0] delta_x;
   logic signed [DELTA_BITS-1:0] delta_y;
   logic signed [SUM_BITS-1:0]   sum_x;
   logic signed [SUM_BITS-1:0]   sum_y;
   logic [COORD_BITS-1:0]        hi_x;
   logic [COORD_BITS-1:0]        hi_y;
   logic [WIDE_BITS-1:0]         width_wide, height_wide;
   logic [WIDE_BITS-1:0]         width_m1, height_m1;
   logic [WIDE_BITS-1:0]         span;

   function automatic logic [COORD_BITS-1:0] clamp_coord(
      input logic signed [SUM_BITS-1:0] v,
      input logic [COORD_BITS-1:0]      hi
   );
      logic signed [SUM_BITS-1:0] hi_s;
      hi_s = $signed({{(SUM_BITS-COORD_BITS){1'b0}}, hi});
      if (v < 0) begin
         return '0;
      end else if (v > hi_s) begin
         return hi;
      end else begin
         return v[COORD_BITS-1:0];
      end
   endfunction

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid & csr_ready;
   assign req_ready = !rsp_valid_ff || rsp_ready || (phase_ff != PHASE_Y);
   assign req_fire  = req_valid & req_ready;

   // The largest coordinate: zero for a zero size, the top code for sizes
   // beyond the coordinate range.
   assign span        = WIDE_BITS'(1) << COORD_BITS;
   assign width_wide  = WIDE_BITS'(width_ff);
   assign height_wide = WIDE_BITS'(height_ff);
   assign width_m1    = width_wide - WIDE_BITS'(1);
   assign height_m1   = height_wide - WIDE_BITS'(1);

   always_comb begin
      if (width_wide == '0) begin
         hi_x = '0;
      end else if (width_wide > span) begin
         hi_x = '1;
      end else begin
         hi_x = width_m1[COORD_BITS-1:0];
      end
      if (height_wide == '0) begin
         hi_y = '0;
      end else if (height_wide > span) begin
         hi_y = '1;
      end else begin
         hi_y = height_m1[COORD_BITS-1:0];
      end
   end

   assign delta_x = decode_delta(x_byte_ff, header_ff[4], header_ff[6]);
   assign delta_y = decode_delta(req_rx_byte, header_ff[5], header_ff[7]);
   assign sum_x   = $signed({{(SUM_BITS-COORD_BITS){1'b0}}, pos_x_ff})
                    + SUM_BITS'(delta_x);
   assign sum_y   = $signed({{(SUM_BITS-COORD_BITS){1'b0}}, pos_y_ff})
                    - SUM_BITS'(delta_y);

   always_comb begin
      phase_in        = phase_ff;
      header_in       = header_ff;
      x_byte_in       = x_byte_ff;
      pos_x_in        = pos_x_ff;
      pos_y_in        = pos_y_ff;
      prev_buttons_in = prev_buttons_ff;
      packet_done     = 1'b0;
      if (req_fire) begin
         case (phase_ff)
            PHASE_X: begin
               x_byte_in = req_rx_byte;
               phase_in  = PHASE_Y;
            end
            PHASE_Y: begin
               pos_x_in        = clamp_coord(sum_x, hi_x);
               pos_y_in        = clamp_coord(sum_y, hi_y);
               prev_buttons_in = header_ff[2:0];
               packet_done     = 1'b1;
               phase_in        = PHASE_HEADER;
            end
            default: begin
               if (req_rx_byte[3]) begin
                  header_in = req_rx_byte;
                  phase_in  = PHASE_X;
               end else begin
                  phase_in  = PHASE_HEADER;
               end
            end
         endcase
      end
   end

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_fire) begin
         case (csr_index)
            REG_SCREEN_WIDTH:  width_in  = csr_data;
            REG_SCREEN_HEIGHT: height_in = csr_data;
            default: begin
               width_in  = width_ff;
               height_in = height_ff;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      down_in      = down_ff;
      pressed_in   = pressed_ff;
      if (packet_done) begin
         rsp_valid_in = 1'b1;
         down_in      = header_ff[2:0];
         pressed_in   = header_ff[2:0] & ~prev_buttons_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PHASE_HEADER;
         header_ff       <= '0;
         x_byte_ff       <= '0;
         pos_x_ff        <= '0;
         pos_y_ff        <= '0;
         prev_buttons_ff <= '0;
         width_ff        <= SCREEN_WIDTH_RESET;
         height_ff       <= SCREEN_HEIGHT_RESET;
         rsp_valid_ff    <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         header_ff       <= header_in;
         x_byte_ff       <= x_byte_in;
         pos_x_ff        <= pos_x_in;
         pos_y_ff        <= pos_y_in;
         prev_buttons_ff <= prev_buttons_in;
         width_ff        <= width_in;
         height_ff       <= height_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      down_ff    <= down_in;
      pressed_ff <= pressed_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_cursor_x       = pos_x_ff;
   assign rsp_cursor_y       = pos_y_ff;
   assign rsp_left_down      = down_ff[0];
   assign rsp_right_down     = down_ff[1];
   assign rsp_middle_down    = down_ff[2];
   assign rsp_left_pressed   = pressed_ff[0];
   assign rsp_right_pressed  = pressed_ff[1];
   assign rsp_middle_pressed = pressed_ff[2];

   // The third byte of a packet always leaves a beat in the result register.
   assert property (@(posedge clock) disable iff (reset)
      req_fire && (phase_ff == PHASE_Y) |=> rsp_valid_ff)
      else $error("packet completed without a result beat");

   // An X byte is always followed by the Y phase.
   assert property (@(posedge clock) disable iff (reset)
      req_fire && (phase_ff == PHASE_X) |=> (phase_ff == PHASE_Y))
      else $error("X byte did not advance to the Y phase");

   // A header byte without its always-one bit leaves the framing unchanged.
   assert property (@(posedge clock) disable iff (reset)
      req_fire && (phase_ff == PHASE_HEADER) && !req_rx_byte[3]
      |=> (phase_ff == PHASE_HEADER) && $stable(header_ff))
      else $error("invalid header byte was taken");

   // The input side stalls only for a Y byte behind a held result beat.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid_ff && !rsp_ready && (phase_ff == PHASE_Y))
      else $error("input stalled without a pending result beat");

endmodule

>>> test/ps2_mouse_packet_tracker_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PS/2 mouse packet tracker testbench
// Feeds mouse bytes through the request channel, predicts every packet
// report from its own model of the framing, delta decode and clamping
// (directed rows carry their own), and checks each report beat field by
// field. A short table of directed bytes comes first, then random packets
// and noise under several screen sizes and idling patterns on both channels.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_tracker_tb;
   import ps2mt_pkg::*;

   localparam int COORD_BITS       = 12;
   localparam int COORD_MAX        = (1 << COORD_BITS) - 1;
   localparam int BYTES_PER_PHASE  = 228;
   localparam int SCREEN_PHASES    = 8;
   localparam int DIRECTED_ROWS    = 26;

   typedef struct packed {
      logic [COORD_BITS-1:0] cursor_x;
      logic [COORD_BITS-1:0] cursor_y;
      logic [2:0]            down;
      logic [2:0]            pressed;
   } mouse_report_type;

   typedef struct packed {
      logic [7:0]       rx_byte;
      logic             typed;
      mouse_report_type report;
   } directed_row_type;

   logic                      clock;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [7:0]                req_rx_byte = 8'd0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [COORD_BITS-1:0]     rsp_cursor_x;
   logic [COORD_BITS-1:0]     rsp_cursor_y;
   logic                      rsp_left_down;
   logic                      rsp_right_down;
   logic                      rsp_middle_down;
   logic                      rsp_left_pressed;
   logic                      rsp_right_pressed;
   logic                      rsp_middle_pressed;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = REG_SCREEN_WIDTH;
   logic [CSR_DATA_BITS-1:0]  csr_data = '0;

   phase_type     trk_phase;
   logic [7:0]    trk_header;
   logic [7:0]    trk_x_byte;
   int            trk_pos_x;
   int            trk_pos_y;
   logic [2:0]    trk_prev_buttons;
   int            scr_width;
   int            scr_height;

   mouse_report_type pending_reports[$];
   int               mismatch_count = 0;
   int               send_idle_pct = 0;
   int               stall_pct = 0;
   directed_row_type directed_rows[DIRECTED_ROWS];

   ps2_mouse_packet_tracker #(
      .COORD_BITS(COORD_BITS)
   ) u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_cursor_x       (rsp_cursor_x),
      .rsp_cursor_y       (rsp_cursor_y),
      .rsp_left_down      (rsp_left_down),
      .rsp_right_down     (rsp_right_down),
      .rsp_middle_down    (rsp_middle_down),
      .rsp_left_pressed   (rsp_left_pressed),
      .rsp_right_pressed  (rsp_right_pressed),
      .rsp_middle_pressed (rsp_middle_pressed),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("FAIL ps2_mouse_packet_tracker");
      $finish;
   end

   function automatic int motion_delta(input logic [7:0] low, input logic neg,
                                       input logic ovf);
      int d;
      d = low;
      if (neg) d = d - 256;
      if (ovf) d = neg ? d - 255 : d + 255;
      return d;
   endfunction

   function automatic int clamp_to_screen(input int v, input int res);
      int hi;
      if (res == 0) hi = 0;
      else if (res - 1 > COORD_MAX) hi = COORD_MAX;
      else hi = res - 1;
      if (v < 0) return 0;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic bit track_mouse_byte(input logic [7:0] b,
                                           output mouse_report_type rep);
      int         dx;
      int         dy;
      logic [2:0] buttons;
      rep = '0;
      case (trk_phase)
         PHASE_X: begin
            trk_x_byte = b;
            trk_phase = PHASE_Y;
         end
         PHASE_Y: begin
            trk_phase = PHASE_HEADER;
            dx = motion_delta(trk_x_byte, trk_header[4], trk_header[6]);
            dy = motion_delta(b, trk_header[5], trk_header[7]);
            trk_pos_x = clamp_to_screen(trk_pos_x + dx, scr_width);
            trk_pos_y = clamp_to_screen(trk_pos_y - dy, scr_height);
            buttons = trk_header[2:0];
            rep.cursor_x = trk_pos_x[COORD_BITS-1:0];
            rep.cursor_y = trk_pos_y[COORD_BITS-1:0];
            rep.down = buttons;
            rep.pressed = buttons & ~trk_prev_buttons;
            trk_prev_buttons = buttons;
            return 1'b1;
         end
         default: begin
            if (b[3]) begin
               trk_header = b;
               trk_phase = PHASE_X;
            end else begin
               trk_phase = PHASE_HEADER;
            end
         end
      endcase
      return 1'b0;
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic typed,
                            input mouse_report_type typed_rep);
      mouse_report_type rep;
      bit               produced;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      produced = track_mouse_byte(b, rep);
      if (produced) pending_reports.push_back(typed ? typed_rep : rep);
      @(negedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_reports.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == REG_SCREEN_WIDTH) scr_width = data;
      else scr_height = data;
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic send_random_packets();
      int         sent;
      int         packets;
      bit         drift;
      logic [7:0] hdr;
      sent = 0;
      packets = 0;
      drift = 1'b0;
      while (sent < BYTES_PER_PHASE) begin
         if ($urandom_range(0, 9) == 0) begin
            send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
            sent = sent + 1;
         end else begin
            hdr = 8'($urandom_range(0, 255)) | 8'h08;
            if ($urandom_range(0, 1) == 1) begin
               hdr[4] = drift;
               hdr[5] = ~drift;
            end
            send_byte(hdr, 1'b0, '0);
            send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
            send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
            sent = sent + 3;
            packets = packets + 1;
            if (packets % 32 == 0) drift = ~drift;
         end
      end
   endtask

   task automatic check_field(input string name, input int expected, input int actual);
      if (expected != actual) begin
         $error("%s: expected %0d, got %0d", name, expected, actual);
         mismatch_count = mismatch_count + 1;
      end
   endtask

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   always @(posedge clock) begin
      mouse_report_type exp_rep;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (pending_reports.size() == 0) begin
            $error("report beat with no packet outstanding: x %0d y %0d",
                   rsp_cursor_x, rsp_cursor_y);
            mismatch_count = mismatch_count + 1;
         end else begin
            exp_rep = pending_reports.pop_front();
            check_field("cursor_x", exp_rep.cursor_x, rsp_cursor_x);
            check_field("cursor_y", exp_rep.cursor_y, rsp_cursor_y);
            check_field("left_down", exp_rep.down[0], rsp_left_down);
            check_field("right_down", exp_rep.down[1], rsp_right_down);
            check_field("middle_down", exp_rep.down[2], rsp_middle_down);
            check_field("left_pressed", exp_rep.pressed[0], rsp_left_pressed);
            check_field("right_pressed", exp_rep.pressed[1], rsp_right_pressed);
            check_field("middle_pressed", exp_rep.pressed[2], rsp_middle_pressed);
         end
      end
   end

   initial begin
      int w;
      int h;
      directed_rows = '{
         '{8'h00, 1'b0, mouse_report_type'(0)},
         '{8'hF7, 1'b0, mouse_report_type'(0)},
         '{8'h08, 1'b0, mouse_report_type'(0)},
         '{8'h00, 1'b0, mouse_report_type'(0)},
         '{8'h00, 1'b1, '{12'd0, 12'd0, 3'd0, 3'd0}},
         '{8'h0F, 1'b0, mouse_report_type'(0)},
         '{8'hFF, 1'b0, mouse_report_type'(0)},
         '{8'h00, 1'b1, '{12'd255, 12'd0, 3'd7, 3'd7}},
         '{8'h4F, 1'b0, mouse_report_type'(0)},
         '{8'hFF, 1'b0, mouse_report_type'(0)},
         '{8'h00, 1'b1, '{12'd765, 12'd0, 3'd7, 3'd0}},
         '{8'h48, 1'b0, mouse_report_type'(0)},
         '{8'hFF, 1'b0, mouse_report_type'(0)},
         '{8'h00, 1'b1, '{12'd1023, 12'd0, 3'd0, 3'd0}},
         '{8'h28, 1'b0, mouse_report_type'(0)},
         '{8'h00, 1'b0, mouse_report_type'(0)},
         '{8'h00, 1'b1, '{12'd1023, 12'd256, 3'd0, 3'd0}},
         '{8'hA8, 1'b0, mouse_report_type'(0)},
         '{8'h00, 1'b0, mouse_report_type'(0)},
         '{8'h00, 1'b1, '{12'd1023, 12'd767, 3'd0, 3'd0}},
         '{8'h19, 1'b0, mouse_report_type'(0)},
         '{8'h00, 1'b0, mouse_report_type'(0)},
         '{8'h7F, 1'b1, '{12'd767, 12'd640, 3'd1, 3'd1}},
         '{8'h5A, 1'b0, mouse_report_type'(0)},
         '{8'h01, 1'b0, mouse_report_type'(0)},
         '{8'hFF, 1'b1, '{12'd257, 12'd385, 3'd2, 3'd2}}
      };
      trk_phase = PHASE_HEADER;
      trk_header = '0;
      trk_x_byte = '0;
      trk_pos_x = 0;
      trk_pos_y = 0;
      trk_prev_buttons = '0;
      scr_width = SCREEN_WIDTH_RESET;
      scr_height = SCREEN_HEIGHT_RESET;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) begin
         send_byte(directed_rows[i].rx_byte, directed_rows[i].typed,
                   directed_rows[i].report);
      end
      settle();

      for (int p = 0; p < SCREEN_PHASES; p++) begin
         case (p)
            0: begin w = 4096; h = 4096; end
            1: begin w = 1; h = 1; end
            2: begin w = 0; h = 0; end
            3: begin w = 8191; h = 8191; end
            4: begin w = 4097; h = 2; end
            5: begin w = 640; h = 480; end
            6: begin w = $urandom_range(1, 4096); h = $urandom_range(1, 4096); end
            default: begin w = $urandom_range(0, 8191); h = $urandom_range(0, 8191); end
         endcase
         write_reg(REG_SCREEN_WIDTH, CSR_DATA_BITS'(w));
         write_reg(REG_SCREEN_HEIGHT, CSR_DATA_BITS'(h));
         case (p % 4)
            0: begin send_idle_pct = 0; stall_pct = 0; end
            1: begin send_idle_pct = 71; stall_pct = 0; end
            2: begin send_idle_pct = 0; stall_pct = 71; end
            default: begin send_idle_pct = 34; stall_pct = 34; end
         endcase
         send_random_packets();
         settle();
      end

      repeat (10) @(negedge clock);
      if (mismatch_count == 0 && pending_reports.size() == 0) begin
         $display("PASS ps2_mouse_packet_tracker");
      end else begin
         $display("FAIL ps2_mouse_packet_tracker");
      end
      $finish;
   end

endmodule
